// ===== sv/sacl_pkg.sv =====
// shared constants and types of the set-associative tag lookup
// geometry, replacement codes, tag row and lookup result types
// no dependencies
package sacl_pkg;

  localparam int unsigned WAYS        = 4;
  localparam int unsigned SET_BITS    = 6;
  localparam int unsigned OFFSET_BITS = 6;
  localparam int unsigned ADDR_BITS   = 32;
  localparam int unsigned TAG_BITS    = ADDR_BITS - SET_BITS - OFFSET_BITS;
  localparam int unsigned SET_COUNT   = 1 << SET_BITS;
  localparam int unsigned RANK_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CNT_BITS    = 32;
  localparam int unsigned LFSR_BITS   = 16;
  localparam logic [LFSR_BITS-1:0] LFSR_SEED = 16'hACE1;

  // replacement policy register codes, the unused code behaves like POL_MRU
  localparam logic [1:0] POL_LRU  = 2'd0;
  localparam logic [1:0] POL_RAND = 2'd1;
  localparam logic [1:0] POL_MRU  = 2'd2;

  typedef logic [TAG_BITS-1:0]  tag_t;
  typedef logic [SET_BITS-1:0]  set_t;
  typedef logic [RANK_BITS-1:0] rank_t;
  typedef logic [WAYS-1:0]      vrow_t;
  typedef tag_t [WAYS-1:0]      row_t;

  typedef struct packed {
    logic  hit;
    rank_t hit_rank;
    logic  ev_valid;
    tag_t  ev_tag;
  } lookup_res_t;

endpackage

// ===== sv/sacl_tag_ram.sv =====
// generic single-port-write, single-port-read synchronous ram
// read data registered; no dependencies
module sacl_tag_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 80
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sacl_set_update.sv =====
// hit search, victim choice and recency reorder of one set row
// holds the random victim lfsr; depends on sacl_pkg
module sacl_set_update (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                commit_i,
  input  logic [1:0]          policy_i,
  input  sacl_pkg::tag_t      tag_i,
  input  sacl_pkg::row_t      row_i,
  input  sacl_pkg::vrow_t     vrow_i,
  output sacl_pkg::row_t      row_o,
  output sacl_pkg::vrow_t     vrow_o,
  output sacl_pkg::lookup_res_t res_o
);
  import sacl_pkg::*;

  logic [LFSR_BITS-1:0] lfsr_q, lfsr_d, lfsr_nx;
  logic                 found, free_found, advance;
  rank_t                hit_rank, free_rank, victim, pos;
  tag_t                 front_tag;

  assign lfsr_nx = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[LFSR_BITS-1:1]};

  always_comb begin
    found      = 1'b0;
    hit_rank   = '0;
    free_found = 1'b0;
    free_rank  = '0;
    for (int unsigned r = 0; r < WAYS; r++) begin
      if (!found && vrow_i[r] && (row_i[r] == tag_i)) begin
        found    = 1'b1;
        hit_rank = rank_t'(r);
      end
      if (!free_found && !vrow_i[r]) begin
        free_found = 1'b1;
        free_rank  = rank_t'(r);
      end
    end
  end

  // victim by policy only when the set is full
  always_comb begin
    advance = 1'b0;
    if (free_found) begin
      victim = free_rank;
    end else begin
      case (policy_i)
        POL_LRU:  victim = rank_t'(WAYS - 1);
        POL_RAND: begin
          victim  = rank_t'(lfsr_nx % WAYS);
          advance = !found;
        end
        default:  victim = '0;
      endcase
    end
  end

  assign pos       = found ? hit_rank : victim;
  assign front_tag = found ? row_i[hit_rank] : tag_i;

  // move the line at pos to rank 0, lines at ranks 0 to pos-1 each move one rank higher
  always_comb begin
    for (int unsigned i = 0; i < WAYS; i++) begin
      if (i == 0) begin
        row_o[i]  = front_tag;
        vrow_o[i] = 1'b1;
      end else if (rank_t'(i) <= pos) begin
        row_o[i]  = row_i[i-1];
        vrow_o[i] = vrow_i[i-1];
      end else begin
        row_o[i]  = row_i[i];
        vrow_o[i] = vrow_i[i];
      end
    end
  end

  assign res_o.hit      = found;
  assign res_o.hit_rank = hit_rank;
  assign res_o.ev_valid = !found && !free_found;
  assign res_o.ev_tag   = (!found && !free_found) ? row_i[victim] : '0;

  assign lfsr_d = (commit_i && advance) ? lfsr_nx : lfsr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= LFSR_SEED;
    end else begin
      lfsr_q <= lfsr_d;
    end
  end

endmodule

// ===== sv/set_assoc_cache_tag_lookup_unit.sv =====
// top level of the set-associative tag directory with recency replacement
// the address word is registered on accept, the result word on commit from the lookup state;
// no new word is taken until the tag ram read and write-back of the last are done;
// a held result word keeps the lookup waiting until the output register frees
// reset: valid bits, counters and policy cleared, lfsr seeded, no clearing pass;
// tag ram stays undefined until written; uses sacl_pkg, sacl_tag_ram, sacl_set_update
module set_assoc_cache_tag_lookup_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sacl_pkg::ADDR_BITS-1:0] address_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o,
  output logic [5:0]                   set_index_o,
  output logic [1:0]                   hit_rank_o,
  output logic                         evicted_valid_o,
  output logic [19:0]                  evicted_tag_o,
  output logic [31:0]                  accesses_seen_o,
  output logic [31:0]                  misses_seen_o
);
  import sacl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [1:0]          policy_q;
  tag_t                tag_q;
  set_t                set_q;
  vrow_t               vrow_q;
  vrow_t [SET_COUNT-1:0] valid_q;
  logic [CNT_BITS-1:0] access_q, miss_q, access_nx, miss_nx;

  logic        accept, commit, out_free;
  row_t        rd_row, new_row;
  vrow_t       rd_vrow, new_vrow;
  lookup_res_t res;

  // output register
  logic                out_valid_q;
  logic                hit_q, ev_valid_q;
  set_t                oset_q;
  rank_t               orank_q;
  tag_t                ev_tag_q;
  logic [CNT_BITS-1:0] oacc_q, omiss_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  // the output register must be empty or draining before a result lands
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == ST_LOOK) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_LOOK;
      ST_LOOK: if (commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      policy_q <= POL_LRU;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        policy_q <= cfg_wdata_i;
      end
    end
  end

  // address split and valid row, held through the lookup cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag_q  <= address_i[ADDR_BITS-1 -: TAG_BITS];
      set_q  <= address_i[OFFSET_BITS +: SET_BITS];
      vrow_q <= valid_q[address_i[OFFSET_BITS +: SET_BITS]];
    end
  end

  // tag rows, one per set, read on accept and written back on commit
  sacl_tag_ram #(
    .DEPTH (SET_COUNT),
    .WIDTH ($bits(row_t))
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (set_q),
    .wdata_i (new_row),
    .re_i    (accept),
    .raddr_i (address_i[OFFSET_BITS +: SET_BITS]),
    .rdata_o (rd_row)
  );

  assign rd_vrow = vrow_q;

  sacl_set_update u_set_update (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (commit),
    .policy_i (policy_q),
    .tag_i    (tag_q),
    .row_i    (rd_row),
    .vrow_i   (rd_vrow),
    .row_o    (new_row),
    .vrow_o   (new_vrow),
    .res_o    (res)
  );

  assign access_nx = access_q + CNT_BITS'(1);
  assign miss_nx   = res.hit ? miss_q : miss_q + CNT_BITS'(1);

  // valid bits in flops so reset empties every set at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      access_q <= '0;
      miss_q   <= '0;
    end else if (commit) begin
      valid_q[set_q] <= new_vrow;
      access_q       <= access_nx;
      miss_q         <= miss_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      hit_q      <= res.hit;
      oset_q     <= set_q;
      orank_q    <= res.hit ? res.hit_rank : '0;
      ev_valid_q <= res.ev_valid;
      ev_tag_q   <= res.ev_tag;
      oacc_q     <= access_nx;
      omiss_q    <= miss_nx;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign set_index_o     = oset_q;
  assign hit_rank_o      = orank_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_tag_o   = ev_tag_q;
  assign accesses_seen_o = oacc_q;
  assign misses_seen_o   = omiss_q;

  // valid lines of a set always form a prefix of the recency order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOK) |-> ((rd_vrow & (rd_vrow + vrow_t'(1))) == '0))
    else $error("valid bits of set are not a recency prefix");

  // a hit never reports an eviction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_valid_o))
    else $error("hit and eviction reported together");

  // the accessed line is valid at rank 0 after write-back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> valid_q[$past(set_q)][0])
    else $error("accessed line not valid at rank 0");

  // the miss count moves by exactly one on a miss and not at all on a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (miss_q == ($past(miss_q) + ($past(res.hit) ? 32'd0 : 32'd1))))
    else $error("miss count out of step");

  // nothing is accepted while a word is under lookup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOK) |-> !accept)
    else $error("word accepted during lookup");

endmodule
